/* rtl/core/sac_pkg.sv */
// Shared types and constants of the stick axis calibration block.
// Widths, register indexes, reset values and the item structs passed between stages.
// No dependencies.
package sac_pkg;

   localparam int SAMPLE_BITS    = 12;
   localparam int CHANNEL_BITS   = 12;
   localparam int NUM_BITS       = SAMPLE_BITS + CHANNEL_BITS;
   localparam int REQ_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_BITS = ((CHANNEL_BITS + 7) / 8) * 8;
   localparam int CSR_DATA_BITS  = (SAMPLE_BITS > CHANNEL_BITS) ? SAMPLE_BITS : CHANNEL_BITS;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [SAMPLE_BITS-1:0]  sample_type;
   typedef logic [CHANNEL_BITS-1:0] channel_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CAL_LOW    = 3'd0,
      CSR_CAL_CENTER = 3'd1,
      CSR_CAL_HIGH   = 3'd2,
      CSR_DEAD_BAND  = 3'd3,
      CSR_REVERSE    = 3'd4,
      CSR_OUT_LOW    = 3'd5,
      CSR_OUT_MID    = 3'd6,
      CSR_OUT_HIGH   = 3'd7
   } csr_index_type;

   typedef struct packed {
      sample_type  cal_low;
      sample_type  cal_center;
      sample_type  cal_high;
      sample_type  dead_band;
      logic        reverse;
      channel_type out_low;
      channel_type out_mid;
      channel_type out_high;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      cal_low:    SAMPLE_BITS'(253),
      cal_center: SAMPLE_BITS'(1949),
      cal_high:   SAMPLE_BITS'(3418),
      dead_band:  SAMPLE_BITS'(60),
      reverse:    1'b0,
      out_low:    CHANNEL_BITS'(1000),
      out_mid:    CHANNEL_BITS'(1500),
      out_high:   CHANNEL_BITS'(2000)
   };

   typedef enum logic [1:0] {
      SEG_SINGLE,
      SEG_LOWER,
      SEG_UPPER
   } seg_type;

   // Divider stage contents: nq holds the unused numerator bits on top and the
   // quotient bits shifted in from the bottom.
   typedef struct packed {
      logic                neg;
      logic                zero;
      channel_type         out_start;
      logic [NUM_BITS-1:0] nq;
      sample_type          rem;
      sample_type          den;
   } div_item_type;

   typedef struct packed {
      logic                neg;
      logic                zero;
      channel_type         out_start;
      logic [NUM_BITS-1:0] quo;
   } quo_item_type;

endpackage

/* rtl/core/sac_csr.sv */
// Configuration registers of the stick axis calibration block.
// Depends on sac_pkg.
module sac_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sac_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sac_pkg::CSR_DATA_BITS-1:0]    csr_data,
   output sac_pkg::cfg_type                     cfg
);
   import sac_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_CAL_LOW:    cfg_in.cal_low    = csr_data[SAMPLE_BITS-1:0];
            CSR_CAL_CENTER: cfg_in.cal_center = csr_data[SAMPLE_BITS-1:0];
            CSR_CAL_HIGH:   cfg_in.cal_high   = csr_data[SAMPLE_BITS-1:0];
            CSR_DEAD_BAND:  cfg_in.dead_band  = csr_data[SAMPLE_BITS-1:0];
            CSR_REVERSE:    cfg_in.reverse    = csr_data[0];
            CSR_OUT_LOW:    cfg_in.out_low    = csr_data[CHANNEL_BITS-1:0];
            CSR_OUT_MID:    cfg_in.out_mid    = csr_data[CHANNEL_BITS-1:0];
            CSR_OUT_HIGH:   cfg_in.out_high   = csr_data[CHANNEL_BITS-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/core/sac_front.sv */
// Front stages: input clamp, deadband snap, segment set-up, multiply and
// sign/magnitude split ahead of the divider. Depends on sac_pkg.
module sac_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  sac_pkg::sample_type   in_sample,
   input  sac_pkg::cfg_type      cfg,
   output logic                  out_valid,
   output sac_pkg::div_item_type out_item
);
   import sac_pkg::*;

   localparam int PROD_BITS = SAMPLE_BITS + CHANNEL_BITS + 2;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   // stage 1: clamp
   sample_type x1_ff, x1_in;
   // stage 2: snap and segment choice
   sample_type x2_ff, x2_in;
   seg_type    seg2_ff, seg2_in;
   // stage 3: offsets and spans
   logic signed [SAMPLE_BITS:0]  dx3_ff, dx3_in;
   logic signed [SAMPLE_BITS:0]  run3_ff, run3_in;
   logic signed [CHANNEL_BITS:0] dout3_ff, dout3_in;
   channel_type                  os3_ff, os3_in;
   // stage 4: product
   logic signed [PROD_BITS-1:0]  prod4_ff, prod4_in;
   logic signed [SAMPLE_BITS:0]  run4_ff;
   channel_type                  os4_ff;
   // stage 5: sign and magnitude
   div_item_type                 item5_ff, item5_in;

   logic [SAMPLE_BITS:0] centre_gap;
   sample_type           in_s, in_e;
   channel_type          out_s, out_e;
   logic [PROD_BITS-1:0] mag;
   logic [SAMPLE_BITS:0] den_full;

   always_comb begin
      if (in_sample < cfg.cal_low) begin
         x1_in = cfg.cal_low;
      end else if (in_sample > cfg.cal_high) begin
         x1_in = cfg.cal_high;
      end else begin
         x1_in = in_sample;
      end
   end

   always_comb begin
      centre_gap = (x1_ff >= cfg.cal_center) ? ({1'b0, x1_ff} - {1'b0, cfg.cal_center})
                                             : ({1'b0, cfg.cal_center} - {1'b0, x1_ff});
      x2_in = x1_ff;
      if (cfg.cal_center == '0) begin
         seg2_in = SEG_SINGLE;
      end else begin
         // snap only strictly inside the deadband
         if (centre_gap < {1'b0, cfg.dead_band}) begin
            x2_in = cfg.cal_center;
         end
         seg2_in = (x2_in <= cfg.cal_center) ? SEG_LOWER : SEG_UPPER;
      end
   end

   always_comb begin
      case (seg2_ff)
         SEG_LOWER: begin
            in_s  = cfg.cal_low;
            in_e  = cfg.cal_center;
            out_s = cfg.out_low;
            out_e = cfg.out_mid;
         end
         SEG_UPPER: begin
            in_s  = cfg.cal_center;
            in_e  = cfg.cal_high;
            out_s = cfg.out_mid;
            out_e = cfg.out_high;
         end
         default: begin
            in_s  = cfg.cal_low;
            in_e  = cfg.cal_high;
            out_s = cfg.out_low;
            out_e = cfg.out_high;
         end
      endcase
      dx3_in   = $signed({1'b0, x2_ff}) - $signed({1'b0, in_s});
      run3_in  = $signed({1'b0, in_e}) - $signed({1'b0, in_s});
      dout3_in = $signed({1'b0, out_e}) - $signed({1'b0, out_s});
      os3_in   = out_s;
   end

   assign prod4_in = PROD_BITS'(dx3_ff) * PROD_BITS'(dout3_ff);

   always_comb begin
      mag      = prod4_ff[PROD_BITS-1] ? PROD_BITS'(-prod4_ff) : PROD_BITS'(prod4_ff);
      den_full = run4_ff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-run4_ff)
                                      : (SAMPLE_BITS + 1)'(run4_ff);
      item5_in.neg       = prod4_ff[PROD_BITS-1] ^ run4_ff[SAMPLE_BITS];
      item5_in.zero      = (run4_ff == '0);
      item5_in.out_start = os4_ff;
      item5_in.nq        = mag[NUM_BITS-1:0];
      item5_in.rem       = '0;
      item5_in.den       = den_full[SAMPLE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff    <= x1_in;
         x2_ff    <= x2_in;
         seg2_ff  <= seg2_in;
         dx3_ff   <= dx3_in;
         run3_ff  <= run3_in;
         dout3_ff <= dout3_in;
         os3_ff   <= os3_in;
         prod4_ff <= prod4_in;
         run4_ff  <= run3_ff;
         os4_ff   <= os3_ff;
         item5_ff <= item5_in;
      end
   end

   assign out_valid = v5_ff;
   assign out_item  = item5_ff;

endmodule

/* rtl/core/sac_div.sv */
// Pipelined restoring divider: one quotient bit per stage, NUM_BITS stages.
// Depends on sac_pkg.
module sac_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  sac_pkg::div_item_type in_item,
   output logic                  out_valid,
   output sac_pkg::quo_item_type out_item
);
   import sac_pkg::*;

   logic         v_ff [NUM_BITS];
   logic         v_in [NUM_BITS];
   div_item_type st_ff [NUM_BITS];
   div_item_type st_in [NUM_BITS];

   always_comb begin
      div_item_type         src;
      logic [SAMPLE_BITS:0] trial;
      for (int k = 0; k < NUM_BITS; k++) begin
         if (k == 0) begin
            src     = in_item;
            v_in[k] = in_valid;
         end else begin
            src     = st_ff[k-1];
            v_in[k] = v_ff[k-1];
         end
         // bring down the next numerator bit, subtract where it fits
         trial    = {src.rem, src.nq[NUM_BITS-1]};
         st_in[k] = src;
         st_in[k].nq = {src.nq[NUM_BITS-2:0], 1'b0};
         if (trial >= {1'b0, src.den}) begin
            st_in[k].rem   = SAMPLE_BITS'(trial - {1'b0, src.den});
            st_in[k].nq[0] = 1'b1;
         end else begin
            st_in[k].rem   = trial[SAMPLE_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            v_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            v_ff[k] <= v_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_BITS; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign out_valid          = v_ff[NUM_BITS-1];
   assign out_item.neg       = st_ff[NUM_BITS-1].neg;
   assign out_item.zero      = st_ff[NUM_BITS-1].zero;
   assign out_item.out_start = st_ff[NUM_BITS-1].out_start;
   assign out_item.quo       = st_ff[NUM_BITS-1].nq;

endmodule

/* rtl/core/sac_back.sv */
// Back stages: signed offset add, output clamp, mirror and the output
// register with skid entry. Produces the pipeline advance. Depends on sac_pkg.
module sac_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  sac_pkg::quo_item_type in_item,
   input  sac_pkg::cfg_type      cfg,
   output logic                  adv,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sac_pkg::channel_type  rsp_value
);
   import sac_pkg::*;

   localparam int SUM_BITS = NUM_BITS + 2;

   logic                       v1_ff, v2_ff;
   logic signed [SUM_BITS-1:0] sum1_ff, sum1_in;
   channel_type                clamp2_ff, clamp2_in;
   channel_type                rev;

   logic        out_v_ff, out_v_in, skid_v_ff, skid_v_in;
   channel_type out_ff, out_in, skid_ff, skid_in;
   logic        push, pop;

   logic signed [SUM_BITS-1:0] q_sx, os_sx, lo_sx, hi_sx;

   always_comb begin
      q_sx    = $signed({2'b00, in_item.quo});
      os_sx   = $signed({{(SUM_BITS - CHANNEL_BITS){1'b0}}, in_item.out_start});
      if (in_item.zero) begin
         sum1_in = os_sx;
      end else if (in_item.neg) begin
         sum1_in = os_sx - q_sx;
      end else begin
         sum1_in = os_sx + q_sx;
      end
   end

   always_comb begin
      lo_sx = $signed({{(SUM_BITS - CHANNEL_BITS){1'b0}}, cfg.out_low});
      hi_sx = $signed({{(SUM_BITS - CHANNEL_BITS){1'b0}}, cfg.out_high});
      if (sum1_ff < lo_sx) begin
         clamp2_in = cfg.out_low;
      end else if (sum1_ff > hi_sx) begin
         clamp2_in = cfg.out_high;
      end else begin
         clamp2_in = sum1_ff[CHANNEL_BITS-1:0];
      end
   end

   // mirror within the output range, wrapping to the channel width
   assign rev = cfg.reverse ? CHANNEL_BITS'(cfg.out_low + cfg.out_high - clamp2_ff) : clamp2_ff;

   // hold the pipeline only while the skid entry is taken
   assign adv  = !skid_v_ff;
   assign push = adv && v2_ff;
   assign pop  = out_v_ff && rsp_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_in    = out_ff;
      skid_v_in = skid_v_ff;
      skid_in   = skid_ff;
      if (!out_v_ff || pop) begin
         if (skid_v_ff) begin
            out_in    = skid_ff;
            out_v_in  = 1'b1;
            skid_v_in = 1'b0;
         end else begin
            out_in   = rev;
            out_v_in = push;
         end
      end else if (push) begin
         skid_in   = rev;
         skid_v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (adv) begin
            v1_ff <= in_valid;
            v2_ff <= v1_ff;
         end
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum1_ff   <= sum1_in;
         clamp2_ff <= clamp2_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_v_ff;
   assign rsp_value = out_ff;

endmodule

/* rtl/core/stick_axis_calibrate_top.sv */
// Stick axis calibration: raw ADC sample in, calibrated channel value out.
// Depends on sac_pkg, sac_csr, sac_front, sac_div and sac_back.
//
// Usage:
//   req_ channel takes one raw sample per item; rsp_ channel gives one
//   channel value per item, in order. csr_ channel writes the calibration
//   registers (index 0..7: cal_low, cal_center, cal_high, dead_band,
//   reverse, out_low, out_mid, out_high); csr_ready is always high. Write
//   registers only while no item is in flight.
//   From acceptance to rsp_tvalid an item passes five front stages, one
//   divider stage per quotient bit, two back stages and the output register.
//   Throughput is one item per cycle while the receiver is ready; the
//   divider is fully pipelined.
//   Reset clears all valid bits and loads the default calibration.
//   When the receiver stalls, a finished item waits in the output register
//   and the pipeline still moves one more item into a skid entry; then
//   req_tready drops and every stage holds until the output drains.
module stick_axis_calibrate_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [sac_pkg::REQ_TDATA_BITS-1:0]    req_tdata,  // [11:0] raw_sample
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [sac_pkg::RSP_TDATA_BITS-1:0]    rsp_tdata,  // [11:0] channel_value
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [sac_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sac_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import sac_pkg::*;

   cfg_type      cfg;
   logic         adv;
   logic         front_valid;
   div_item_type front_item;
   logic         div_valid;
   quo_item_type div_item;
   channel_type  rsp_value;

   assign req_tready = adv;

   sac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sac_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_tvalid && req_tready),
      .in_sample (req_tdata[SAMPLE_BITS-1:0]),
      .cfg       (cfg),
      .out_valid (front_valid),
      .out_item  (front_item)
   );

   sac_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   sac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_item   (div_item),
      .cfg       (cfg),
      .adv       (adv),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_value (rsp_value)
   );

   assign rsp_tdata = RSP_TDATA_BITS'(rsp_value);

endmodule

/* test/tb_stick_axis_calibrate_top.sv */
// Testbench for stick_axis_calibrate_top: raw samples are streamed in, and each channel value
// is checked against a predictor of the calibration, under random idling and back-pressure.
// Depends on sac_pkg and the block's RTL.
module tb_stick_axis_calibrate_top;
   import sac_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int LATENCY      = SAMPLE_BITS + CHANNEL_BITS + 8;
   localparam int LIMIT_CYCLES = 200000;
   localparam int HOLD_CYCLES  = 150;
   localparam int IDLE_PERCENT = 27;
   localparam int FULL_SCALE   = (1 << SAMPLE_BITS) - 1;
   localparam int RANDOM_PHASES    = 11;
   localparam int PHASE_SAMPLES    = 32;
   localparam int PRESSURE_SAMPLES = 64;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;    // [11:0] raw_sample
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;          // [11:0] channel_value
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;

   cfg_type     model_cfg = CFG_RST;
   channel_type expected_channel[$];

   bit gaps_on  = 1'b1;
   bit stall_on = 1'b1;
   bit hold_req = 1'b0;

   int items_sent      = 0;
   int items_checked   = 0;
   int configs_applied = 0;
   int input_stalls    = 0;
   int mismatches      = 0;

   stick_axis_calibrate_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic longint segment_value(longint x, longint in_start, longint in_end,
                                            longint out_start, longint out_end);
      longint span;
      span = in_end - in_start;
      if (span == 0)
         return out_start;
      return out_start + ((x - in_start) * (out_end - out_start)) / span;
   endfunction

   function automatic channel_type calibrated_value(cfg_type c, sample_type raw);
      longint lo, ce, hi, db, ol, om, oh, x, v, gap;
      lo = longint'(c.cal_low);
      ce = longint'(c.cal_center);
      hi = longint'(c.cal_high);
      db = longint'(c.dead_band);
      ol = longint'(c.out_low);
      om = longint'(c.out_mid);
      oh = longint'(c.out_high);
      x  = longint'(raw);
      // low bound wins when the calibration is inverted
      if (x < lo)
         x = lo;
      else if (x > hi)
         x = hi;
      if (ce == 0) begin
         v = segment_value(x, lo, hi, ol, oh);
      end else begin
         gap = (x < ce) ? ce - x : x - ce;
         if (gap < db)
            x = ce;
         if (x <= ce)
            v = segment_value(x, lo, ce, ol, om);
         else
            v = segment_value(x, ce, hi, om, oh);
      end
      if (v < ol)
         v = ol;
      else if (v > oh)
         v = oh;
      if (c.reverse)
         v = ol + oh - v;
      return channel_type'(v);
   endfunction

   // ---------------------------------------------------------------- helpers

   function automatic cfg_type make_cfg(int lo, int ce, int hi, int db, bit rev,
                                        int ol, int om, int oh);
      cfg_type c;
      c.cal_low    = sample_type'(lo);
      c.cal_center = sample_type'(ce);
      c.cal_high   = sample_type'(hi);
      c.dead_band  = sample_type'(db);
      c.reverse    = rev;
      c.out_low    = channel_type'(ol);
      c.out_mid    = channel_type'(om);
      c.out_high   = channel_type'(oh);
      return c;
   endfunction

   function automatic void order3(inout int a, inout int b, inout int c);
      int t;
      if (a > b) begin t = a; a = b; b = t; end
      if (b > c) begin t = b; b = c; c = t; end
      if (a > b) begin t = a; a = b; b = t; end
   endfunction

   function automatic cfg_type random_cfg();
      int lo, ce, hi, ol, om, oh, db;
      lo = $urandom_range(FULL_SCALE);
      ce = $urandom_range(FULL_SCALE);
      hi = $urandom_range(FULL_SCALE);
      ol = $urandom_range(FULL_SCALE);
      om = $urandom_range(FULL_SCALE);
      oh = $urandom_range(FULL_SCALE);
      db = $urandom_range(300);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            order3(lo, ce, hi);
            order3(ol, om, oh);
         end
         5, 6: begin
            // single segment
            order3(lo, ce, hi);
            order3(ol, om, oh);
            ce = 0;
         end
         7: begin
            db = $urandom_range(FULL_SCALE);
         end
         8: begin
            lo = $urandom_range(1) * FULL_SCALE;
            ce = $urandom_range(1) * FULL_SCALE;
            hi = $urandom_range(1) * FULL_SCALE;
            db = $urandom_range(1) * FULL_SCALE;
            ol = $urandom_range(1) * FULL_SCALE;
            om = $urandom_range(1) * FULL_SCALE;
            oh = $urandom_range(1) * FULL_SCALE;
         end
         default: begin
            order3(lo, ce, hi);
            order3(ol, om, oh);
            db = 0;
         end
      endcase
      return make_cfg(lo, ce, hi, db, 1'($urandom_range(1)), ol, om, oh);
   endfunction

   // Bias samples towards the calibration points: the centre, where the segments meet, and both ends.
   function automatic sample_type pick_sample(cfg_type c);
      int v, reach;
      reach = int'(c.dead_band) + 3;
      case ($urandom_range(9))
         0, 1, 2, 3: v = $urandom_range(FULL_SCALE);
         4, 5:       v = int'(c.cal_center) + int'($urandom_range(2 * reach)) - reach;
         6:          v = int'(c.cal_low) + int'($urandom_range(8)) - 4;
         7:          v = int'(c.cal_high) + int'($urandom_range(8)) - 4;
         8:          v = $urandom_range(1) * FULL_SCALE;
         default:    v = $urandom_range(1) ? 'hAAA : 'h555;
      endcase
      if (v < 0)
         v = 0;
      else if (v > FULL_SCALE)
         v = FULL_SCALE;
      return sample_type'(v);
   endfunction

   task automatic send_sample(input sample_type raw);
      while (gaps_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'(raw);
      do @(posedge clock); while (req_tready !== 1'b1);
      expected_channel.push_back(calibrated_value(model_cfg, raw));
      items_sent++;
   endtask

   // Leave valid high; the caller lowers it after the last register.
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic apply_config(input cfg_type c);
      logic [CSR_DATA_BITS-1:0] rev_word;
      rev_word    = CSR_DATA_BITS'($urandom);
      rev_word[0] = c.reverse;
      write_reg(CSR_CAL_LOW,    c.cal_low);
      write_reg(CSR_CAL_CENTER, c.cal_center);
      write_reg(CSR_CAL_HIGH,   c.cal_high);
      write_reg(CSR_DEAD_BAND,  c.dead_band);
      write_reg(CSR_REVERSE,    rev_word);
      write_reg(CSR_OUT_LOW,    c.out_low);
      write_reg(CSR_OUT_MID,    c.out_mid);
      write_reg(CSR_OUT_HIGH,   c.out_high);
      csr_valid <= 1'b0;
      model_cfg = c;
      configs_applied++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_channel.size() != 0)
         @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [RSP_TDATA_BITS-1:0] want,
                                  input logic [RSP_TDATA_BITS-1:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at %0t (%s): channel_value expected %h, got %h",
                  $realtime, what, want, got);
   endtask

   // ---------------------------------------------------------------- receiver and checker

   initial begin : receiver
      int hold_count;
      bit hold_done;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req && !hold_done) begin
            // hold off long enough for the pipeline to fill and stall its input
            hold_done  = 1'b1;
            rsp_tready <= 1'b0;
            for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++)
               @(posedge clock);
         end
         rsp_tready <= !(stall_on && $urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin : check_results
      logic [RSP_TDATA_BITS-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready !== 1'b1)
            input_stalls++;
         if (rsp_tvalid === 1'b1 && rsp_tready) begin
            items_checked++;
            if (expected_channel.size() == 0) begin
               report_mismatch("no item outstanding", 'x, rsp_tdata);
            end else begin
               want = RSP_TDATA_BITS'(expected_channel.pop_front());
               if (rsp_tdata !== want)
                  report_mismatch("wrong value", want, rsp_tdata);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_reset_calibration();
      int points[$];
      points = '{'h000, 'hFFF, 253, 252, 1890, 1889, 2009, 3418, 'hAAA, 'h555};
      foreach (points[i])
         send_sample(sample_type'(points[i]));
      drain();
   endtask

   task automatic test_special_cases();
      // full-scale single segment
      apply_config(make_cfg(0, 0, FULL_SCALE, 0, 1'b0, 0, 2048, FULL_SCALE));
      send_sample(sample_type'(0));
      send_sample(sample_type'(FULL_SCALE));
      send_sample(sample_type'(2048));
      drain();
      // inverted calibration and inverted output range, mirrored
      apply_config(make_cfg(3000, 2000, 1000, 100, 1'b1, 3000, 2000, 500));
      send_sample(sample_type'(100));
      send_sample(sample_type'(2999));
      send_sample(sample_type'(3000));
      drain();
      // zero spans, with the widest dead band
      apply_config(make_cfg(1000, 1000, 1000, FULL_SCALE, 1'b0, FULL_SCALE, 0, FULL_SCALE));
      send_sample(sample_type'(0));
      send_sample(sample_type'(FULL_SCALE));
      drain();
      // no dead band, centre value far outside the output range
      apply_config(make_cfg(0, 2048, FULL_SCALE, 0, 1'b0, 100, FULL_SCALE, 200));
      send_sample(sample_type'(2048));
      send_sample(sample_type'(2047));
      send_sample(sample_type'(2049));
      send_sample(sample_type'(1));
      drain();
      // single segment with zero span
      apply_config(make_cfg(500, 0, 500, 0, 1'b0, 7, 9, 4000));
      send_sample(sample_type'(FULL_SCALE));
      drain();
   endtask

   task automatic test_random_calibration();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_config(random_cfg());
         // one phase runs with neither side idling
         gaps_on  = (phase != 3);
         stall_on = (phase != 3);
         repeat (PHASE_SAMPLES)
            send_sample(pick_sample(model_cfg));
         drain();
      end
      gaps_on  = 1'b1;
      stall_on = 1'b1;
   endtask

   task automatic test_backpressure();
      apply_config(random_cfg());
      gaps_on  = 1'b0;
      hold_req <= 1'b1;
      repeat (PRESSURE_SAMPLES)
         send_sample(pick_sample(model_cfg));
      drain();
      gaps_on = 1'b1;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_calibration();
      test_special_cases();
      test_random_calibration();
      test_backpressure();
      repeat (LATENCY + 8) @(posedge clock);
      $display("Sent %0d raw samples under %0d calibration settings, %0d values checked;",
               items_sent, configs_applied, items_checked);
      $display("input held back for %0d cycles, %0d mismatches.", input_stalls, mismatches);
      if (mismatches == 0 && expected_channel.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin : watchdog
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("FAIL");
      $finish;
   end

endmodule

/* files.f */
rtl/core/sac_pkg.sv
rtl/core/sac_csr.sv
rtl/core/sac_front.sv
rtl/core/sac_div.sv
rtl/core/sac_back.sv
rtl/core/stick_axis_calibrate_top.sv
test/tb_stick_axis_calibrate_top.sv
